// File: hw/rtl/ptgi_pkg.sv
// ----------------------------------------------------------------------------
// ptgi_pkg
// Shared constants and types for the periodic trilinear grid interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package ptgi_pkg;

    // Fixed field widths
    localparam int POS_W       = 21;
    localparam int VALUE_W     = 32;
    localparam int ADDR_W      = 15;
    localparam int STORE_DEPTH = 32768;

    // Eight corners of the interpolation cube
    localparam int CORNERS  = 8;
    localparam int CORNER_W = 3;

    // Operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_INTERP = 1'b1;

    // Tag that travels with each corner through the MAC pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctrl;

endpackage

`default_nettype wire

// File: hw/rtl/periodic_trilinear_grid_interp.sv
// ----------------------------------------------------------------------------
// periodic_trilinear_grid_interp
// Periodic 3D grid store with cloud-in-cell (trilinear) interpolation.
// ----------------------------------------------------------------------------
// A write beat stores one signed Q16.16 grid value, and writes can follow
// back to back. A query beat keeps the input stalled while the sequencer
// works through its steps in order: the axis units wrap each axis's cell
// index (a reciprocal multiply, one correcting subtract, one hand-over),
// S_ROW and S_PLANE form the corner addresses, S_CORNER reads the eight
// corners through the single read port of the grid memory, S_DRAIN waits
// out the read latency and the weight and multiply-accumulate pipeline, and
// S_OUT loads the output register, which releases the input. A result the
// receiver has not taken holds the next query only once that query is
// finished. Grid entries must be written before a query reads them.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_trilinear_grid_interp #(
    parameter int CELLS_X   = 32,
    parameter int CELLS_Y   = 32,
    parameter int CELLS_Z   = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic                                i_cfg_data,
    // Input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_operation,
    input  wire logic        [ptgi_pkg::ADDR_W-1:0]  i_write_address,
    input  wire logic signed [ptgi_pkg::VALUE_W-1:0] i_write_value,
    input  wire logic        [ptgi_pkg::POS_W-1:0]   i_pos_x,
    input  wire logic        [ptgi_pkg::POS_W-1:0]   i_pos_y,
    input  wire logic        [ptgi_pkg::POS_W-1:0]   i_pos_z,
    // Output channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed      [ptgi_pkg::VALUE_W-1:0] o_interp_value
);

    import ptgi_pkg::*;

    localparam int CXW = $clog2(CELLS_X);
    localparam int CYW = $clog2(CELLS_Y);
    localparam int CZW = $clog2(CELLS_Z);
    localparam int W_W = FRAC_BITS + 1;

    localparam logic [ADDR_W-1:0]   CY_A        = ADDR_W'(CELLS_Y);
    localparam logic [ADDR_W-1:0]   CZ_A        = ADDR_W'(CELLS_Z);
    localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(CORNERS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AXIS,
        S_ROW,
        S_PLANE,
        S_CORNER,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [CORNER_W-1:0] r_corner;
    logic [ADDR_W-1:0]   r_row   [2];
    logic [ADDR_W-1:0]   r_plane [4];
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_cell_centred_mode;

    logic w_in_accept;
    logic w_start;
    logic w_ram_we;

    logic x_done, y_done, z_done;
    logic [CXW-1:0] x_base, x_nbr;
    logic [CYW-1:0] y_base, y_nbr;
    logic [CZW-1:0] z_base, z_nbr;
    logic [W_W-1:0] x_w_base, x_w_nbr, y_w_base, y_w_nbr, z_w_base, z_w_nbr;

    logic [ADDR_W-1:0]  w_raddr;
    logic [VALUE_W-1:0] w_rdata;
    logic [W_W-1:0]     w_wx, w_wy, w_wz;
    t_mac_ctrl          w_mac_ctrl;
    logic               mac_valid;
    logic [VALUE_W-1:0] mac_result;

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_start     = w_in_accept && (i_operation == OP_INTERP);
    assign w_ram_we    = w_in_accept && (i_operation == OP_WRITE);
    assign o_cfg_ready = 1'b1;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_centred_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cell_centred_mode <= i_cfg_data;
        end
    end

    // Per-axis cell wrap and weights
    ptgi_axis #(.CELLS(CELLS_X), .FRAC_BITS(FRAC_BITS)) u_axis_x (
        .i_clk, .i_rst_n, .i_start(w_start), .i_centred(r_cell_centred_mode),
        .i_pos(i_pos_x), .o_done(x_done), .o_base(x_base), .o_nbr(x_nbr),
        .o_w_base(x_w_base), .o_w_nbr(x_w_nbr)
    );
    ptgi_axis #(.CELLS(CELLS_Y), .FRAC_BITS(FRAC_BITS)) u_axis_y (
        .i_clk, .i_rst_n, .i_start(w_start), .i_centred(r_cell_centred_mode),
        .i_pos(i_pos_y), .o_done(y_done), .o_base(y_base), .o_nbr(y_nbr),
        .o_w_base(y_w_base), .o_w_nbr(y_w_nbr)
    );
    ptgi_axis #(.CELLS(CELLS_Z), .FRAC_BITS(FRAC_BITS)) u_axis_z (
        .i_clk, .i_rst_n, .i_start(w_start), .i_centred(r_cell_centred_mode),
        .i_pos(i_pos_z), .o_done(z_done), .o_base(z_base), .o_nbr(z_nbr),
        .o_w_base(z_w_base), .o_w_nbr(z_w_nbr)
    );

    // Corner select: bit 2 picks x neighbor, bit 1 y, bit 0 z
    assign w_raddr = r_plane[r_corner[2:1]]
                   + ADDR_W'(r_corner[0] ? z_nbr : z_base);
    assign w_wx    = r_corner[2] ? x_w_nbr : x_w_base;
    assign w_wy    = r_corner[1] ? y_w_nbr : y_w_base;
    assign w_wz    = r_corner[0] ? z_w_nbr : z_w_base;

    assign w_mac_ctrl.valid = (r_state == S_CORNER);
    assign w_mac_ctrl.first = (r_corner == '0);
    assign w_mac_ctrl.last  = (r_corner == LAST_CORNER);

    // Grid memory
    ptgi_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_grid (
        .i_clk,
        .i_we    (w_ram_we),
        .i_waddr (i_write_address),
        .i_wdata (i_write_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Weight and accumulate pipeline
    ptgi_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk, .i_rst_n,
        .i_ctrl    (w_mac_ctrl),
        .i_wx      (w_wx),
        .i_wy      (w_wy),
        .i_wz      (w_wz),
        .i_rd_data (w_rdata),
        .o_valid   (mac_valid),
        .o_result  (mac_result)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_corner    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a finished query, or clear once the beat is taken
            if ((r_state == S_OUT) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
                r_out_value <= mac_result;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_corner <= '0;
                    if (w_start) begin
                        r_state <= S_AXIS;
                    end
                end
                S_AXIS: begin
                    if (x_done) begin
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    // Flattened index is taken modulo the store size
                    r_row[0] <= CY_A * ADDR_W'(x_base);
                    r_row[1] <= CY_A * ADDR_W'(x_nbr);
                    r_state  <= S_PLANE;
                end
                S_PLANE: begin
                    r_plane[0] <= CZ_A * (r_row[0] + ADDR_W'(y_base));
                    r_plane[1] <= CZ_A * (r_row[0] + ADDR_W'(y_nbr));
                    r_plane[2] <= CZ_A * (r_row[1] + ADDR_W'(y_base));
                    r_plane[3] <= CZ_A * (r_row[1] + ADDR_W'(y_nbr));
                    r_state    <= S_CORNER;
                end
                S_CORNER: begin
                    r_corner <= r_corner + CORNER_W'(1);
                    if (r_corner == LAST_CORNER) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (mac_valid) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_interp_value = r_out_value;

    // Assertions
    a_axis_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_done |-> (y_done && z_done && (r_state == S_AXIS)))
        else $error("axis units out of step");

    a_mac_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_valid |-> (r_state == S_DRAIN))
        else $error("accumulated result outside drain");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("output loaded without a finished query");

endmodule

`default_nettype wire

// File: hw/rtl/ptgi_ram.sv
// ----------------------------------------------------------------------------
// ptgi_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32768,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/ptgi_axis.sv
// ----------------------------------------------------------------------------
// ptgi_axis
// One axis of the query: splits the position into cell and offset, wraps the
// cell index with a reciprocal-multiply remainder, picks neighbor and weights.
// ----------------------------------------------------------------------------
`default_nettype none

module ptgi_axis #(
    parameter int CELLS     = 32,
    parameter int FRAC_BITS = 16,
    localparam int CELL_W = $clog2(CELLS),
    localparam int W_W    = FRAC_BITS + 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic                       i_centred,
    input  wire logic [ptgi_pkg::POS_W-1:0] i_pos,
    output logic                            o_done,
    output logic      [CELL_W-1:0]          o_base,
    output logic      [CELL_W-1:0]          o_nbr,
    output logic      [W_W-1:0]             o_w_base,
    output logic      [W_W-1:0]             o_w_nbr
);

    import ptgi_pkg::*;

    localparam int INT_W  = (POS_W > FRAC_BITS) ? POS_W - FRAC_BITS : 1;
    localparam int PROD_W = 2 * INT_W + 1;
    localparam int CMP_W  = (INT_W > CELL_W) ? INT_W : CELL_W + 1;
    localparam int EXT_W  = POS_W + FRAC_BITS;

    localparam logic [FRAC_BITS-1:0] HALF      = FRAC_BITS'(1 << (FRAC_BITS - 1));
    localparam logic [W_W-1:0]       ONE       = W_W'(1 << FRAC_BITS);
    // floor(2^INT_W / CELLS): the quotient estimate is exact or one low
    localparam logic [PROD_W-1:0]    RECIP     = PROD_W'((1 << INT_W) / CELLS);
    localparam logic [INT_W-1:0]     CELLS_Q   = INT_W'(CELLS);
    localparam logic [CMP_W-1:0]     CELLS_C   = CMP_W'(CELLS);
    localparam logic [CELL_W-1:0]    LAST_CELL = CELL_W'(CELLS - 1);

    logic [EXT_W-1:0]     w_ext;
    logic [FRAC_BITS-1:0] w_frac;
    logic [POS_W-1:0]     w_int_full;
    logic                 w_below;
    logic [FRAC_BITS-1:0] w_d;
    logic [PROD_W-1:0]    w_prod;
    logic [INT_W-1:0]     w_rem_est;
    logic [CMP_W-1:0]     w_rem_ext;

    logic [INT_W-1:0]     r_int;
    logic [INT_W-1:0]     r_quot;
    logic [CELL_W-1:0]    r_rem;
    logic                 r_int_vld;
    logic                 r_quot_vld;
    logic                 r_done;
    logic                 r_down;
    logic [FRAC_BITS-1:0] r_d;

    // Split position into integer cell and fraction
    assign w_ext      = {{FRAC_BITS{1'b0}}, i_pos};
    assign w_frac     = w_ext[FRAC_BITS-1:0];
    assign w_int_full = i_pos >> FRAC_BITS;
    assign w_below    = i_centred && (w_frac < HALF);

    // Offset magnitude: from the center or from the corner
    always_comb begin
        if (!i_centred) begin
            w_d = w_frac;
        end else if (w_below) begin
            w_d = HALF - w_frac;
        end else begin
            w_d = w_frac - HALF;
        end
    end

    // Quotient estimate, then remainder with one correcting subtract
    assign w_prod    = PROD_W'(r_int) * RECIP;
    assign w_rem_est = r_int - r_quot * CELLS_Q;
    assign w_rem_ext = CMP_W'(w_rem_est);

    // Step sequencing: integer loaded, quotient ready, remainder ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_vld  <= 1'b0;
            r_quot_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_int_vld  <= i_start;
            r_quot_vld <= r_int_vld;
            r_done     <= r_quot_vld;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_int  <= INT_W'(w_int_full);
            r_down <= w_below;
            r_d    <= w_d;
        end
        if (r_int_vld) begin
            r_quot <= w_prod[INT_W +: INT_W];
        end
        if (r_quot_vld) begin
            r_rem <= (w_rem_ext >= CELLS_C) ? CELL_W'(w_rem_ext - CELLS_C)
                                            : CELL_W'(w_rem_ext);
        end
    end

    // Neighbor wraps around the grid edge
    always_comb begin
        if (r_down) begin
            o_nbr = (r_rem == '0) ? LAST_CELL : r_rem - CELL_W'(1);
        end else begin
            o_nbr = (r_rem == LAST_CELL) ? '0 : r_rem + CELL_W'(1);
        end
    end

    assign o_done   = r_done;
    assign o_base   = r_rem;
    assign o_w_nbr  = {1'b0, r_d};
    assign o_w_base = ONE - {1'b0, r_d};

endmodule

`default_nettype wire

// File: hw/rtl/ptgi_mac.sv
// ----------------------------------------------------------------------------
// ptgi_mac
// Corner pipeline: builds the trilinear weight, multiplies it with the grid
// value read from memory and accumulates eight corners; floors and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module ptgi_mac #(
    parameter int FRAC_BITS = 16,
    localparam int W_W = FRAC_BITS + 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire ptgi_pkg::t_mac_ctrl                 i_ctrl,
    input  wire logic        [W_W-1:0]               i_wx,
    input  wire logic        [W_W-1:0]               i_wy,
    input  wire logic        [W_W-1:0]               i_wz,
    input  wire logic signed [ptgi_pkg::VALUE_W-1:0] i_rd_data,
    output logic                                     o_valid,
    output logic signed      [ptgi_pkg::VALUE_W-1:0] o_result
);

    import ptgi_pkg::*;

    localparam int PROD_W = VALUE_W + W_W + 1;
    localparam int SUM_W  = PROD_W + 3;
    localparam int SH_W   = SUM_W - FRAC_BITS;

    t_mac_ctrl r_c1, r_c2, r_c3;

    logic        [2*W_W-1:0]   r_wxy;
    logic        [W_W-1:0]     r_wz1;
    logic        [2*W_W-1:0]   r_w;
    logic signed [VALUE_W-1:0] r_v;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_acc;
    logic                      r_fin;
    logic                      r_valid;
    logic signed [VALUE_W-1:0] r_result;

    logic        [W_W-1:0]         w_wxy_t;
    logic        [W_W-1:0]         w_wt;
    logic signed [SUM_W-1:0]       w_prod_ext;
    logic signed [SH_W-1:0]        w_sh;
    logic        [SH_W-VALUE_W:0]  w_top;
    logic                          w_ovf;
    logic signed [VALUE_W-1:0]     w_sat;

    // Truncated weight products
    assign w_wxy_t    = r_wxy[FRAC_BITS +: W_W];
    assign w_wt       = r_w[FRAC_BITS +: W_W];
    assign w_prod_ext = SUM_W'(r_prod);

    // Floor by arithmetic shift, then saturate to 32 bits
    assign w_sh  = SH_W'(r_acc >>> FRAC_BITS);
    assign w_top = w_sh[SH_W-1:VALUE_W-1];
    assign w_ovf = !((w_top == '0) || (w_top == '1));
    always_comb begin
        if (w_ovf) begin
            w_sat = w_sh[SH_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                 : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
            w_sat = w_sh[VALUE_W-1:0];
        end
    end

    // Pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1    <= '0;
            r_c2    <= '0;
            r_c3    <= '0;
            r_fin   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_c1    <= i_ctrl;
            r_c2    <= r_c1;
            r_c3    <= r_c2;
            r_fin   <= r_c3.valid && r_c3.last;
            r_valid <= r_fin;
        end
    end

    // Datapath: wx*wy, then *wz with memory data arriving, then value*weight
    always_ff @(posedge i_clk) begin
        r_wxy  <= i_wx * i_wy;
        r_wz1  <= i_wz;
        r_w    <= w_wxy_t * r_wz1;
        r_v    <= i_rd_data;
        r_prod <= r_v * $signed({1'b0, w_wt});
        if (r_c3.valid) begin
            r_acc <= r_c3.first ? w_prod_ext : r_acc + w_prod_ext;
        end
        if (r_fin) begin
            r_result <= w_sat;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: tb/sv/tb_periodic_trilinear_grid_interp.sv
// ----------------------------------------------------------------------------
// tb_periodic_trilinear_grid_interp
// Self-checking bench for the periodic trilinear grid interpolator. Write beats
// load grid entries; query beats are predicted by an internal model of the
// cloud-in-cell blend (periodic neighbors, both offset modes, truncated
// weights, floored sum). Every query corner is loaded before it is read. The
// run steps through both offset modes under several idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_periodic_trilinear_grid_interp;

    import ptgi_pkg::*;

    localparam int CELLS_X    = 32;
    localparam int CELLS_Y    = 32;
    localparam int CELLS_Z    = 32;
    localparam int FRAC_BITS  = 16;
    localparam longint ONE    = 64'd1 << FRAC_BITS;
    localparam longint HALF   = 64'd1 << (FRAC_BITS - 1);
    localparam int PHASES     = 6;
    localparam int RAND_BEATS = 285;
    localparam int SETTLE     = 40;
    localparam int CYCLE_CAP  = 1000000;

    typedef struct {
        logic                      operation;
        logic        [ADDR_W-1:0]  addr;
        logic signed [VALUE_W-1:0] value;
        logic        [POS_W-1:0]   px;
        logic        [POS_W-1:0]   py;
        logic        [POS_W-1:0]   pz;
        bit                        hold;
    } t_grid_beat;

    typedef struct {
        logic        [POS_W-1:0]   px;
        logic        [POS_W-1:0]   py;
        logic        [POS_W-1:0]   pz;
        logic signed [VALUE_W-1:0] value;
    } t_interp_expect;

    // Clock, reset and DUT-facing signals
    logic                      i_clk       = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_data    = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      op_r        = OP_WRITE;
    logic        [ADDR_W-1:0]  addr_r      = '0;
    logic signed [VALUE_W-1:0] value_r     = '0;
    logic        [POS_W-1:0]   px_r        = '0;
    logic        [POS_W-1:0]   py_r        = '0;
    logic        [POS_W-1:0]   pz_r        = '0;
    logic                      out_stall   = 1'b0;
    logic                      o_cfg_ready;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic signed [VALUE_W-1:0] o_interp_value;

    // Bench state
    t_grid_beat     pending_beats[$];
    t_interp_expect expected_interp[$];
    logic [VALUE_W-1:0] grid_model [0:STORE_DEPTH-1];
    bit   cells_loaded [0:STORE_DEPTH-1];
    bit   centred_mode  = 1'b1;
    int   send_gap_pct  = 0;
    int   recv_stall_pct = 0;
    int   beats_queued  = 0;
    int   writes_taken  = 0;
    int   queries_taken = 0;
    int   results_checked = 0;
    int   mismatches    = 0;
    int   cycle_count   = 0;

    periodic_trilinear_grid_interp #(
        .CELLS_X   (CELLS_X),
        .CELLS_Y   (CELLS_Y),
        .CELLS_Z   (CELLS_Z),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (op_r),
        .i_write_address (addr_r),
        .i_write_value   (value_r),
        .i_pos_x         (px_r),
        .i_pos_y         (py_r),
        .i_pos_z         (pz_r),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_interp_value  (o_interp_value)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Per-axis base cell, neighbor cell and their weights
    function automatic void resolve_axis(input logic [POS_W-1:0] pos, input int cells,
                                         output int base, output int nbr,
                                         output longint w_base, output longint w_nbr);
        longint frac;
        longint d;
        int     cell_idx;
        bit     down;
        frac     = longint'(pos) & (ONE - 1);
        cell_idx = int'(pos >> FRAC_BITS) % cells;
        down     = 1'b0;
        if (centred_mode) begin
            if (frac < HALF) begin
                d    = HALF - frac;
                down = 1'b1;
            end else begin
                d = frac - HALF;
            end
        end else begin
            d = frac;
        end
        base   = cell_idx;
        nbr    = down ? (cell_idx + cells - 1) % cells : (cell_idx + 1) % cells;
        w_nbr  = d;
        w_base = ONE - d;
    endfunction

    function automatic int corner_addr(input int x, input int y, input int z);
        return (z + CELLS_Z * (y + CELLS_Y * x)) % STORE_DEPTH;
    endfunction

    // Trilinear blend of the eight corners, floored to Q16.16 and saturated
    function automatic logic signed [VALUE_W-1:0] predict_interp(
        input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
        input logic [POS_W-1:0] pz);
        int     cx[2], cy[2], cz[2];
        longint wx[2], wy[2], wz[2];
        longint acc;
        longint w;
        longint v;
        resolve_axis(px, CELLS_X, cx[0], cx[1], wx[0], wx[1]);
        resolve_axis(py, CELLS_Y, cy[0], cy[1], wy[0], wy[1]);
        resolve_axis(pz, CELLS_Z, cz[0], cz[1], wz[0], wz[1]);
        acc = 0;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                for (int k = 0; k < 2; k++) begin
                    w   = (((wx[i] * wy[j]) >> FRAC_BITS) * wz[k]) >> FRAC_BITS;
                    v   = $signed(grid_model[corner_addr(cx[i], cy[j], cz[k])]);
                    acc = acc + v * w;
                end
        acc = acc >>> FRAC_BITS;
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc[VALUE_W-1:0];
    endfunction

    // Stimulus builders
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_axis(input bit near);
        int cell_idx;
        logic [4:0]           cell_bits;
        logic [FRAC_BITS-1:0] f;
        if (!near && $urandom_range(1))
            return POS_W'($urandom_range(21'h1F_FFFF));
        cell_idx = $urandom_range(5);
        if (near)
            cell_idx = (cell_idx < 3) ? cell_idx : 26 + cell_idx;
        else
            cell_idx = $urandom_range(CELLS_X - 1);
        case ($urandom_range(5))
            0:       f = '0;
            1:       f = 16'h8000;
            2:       f = 16'hFFFF;
            default: f = FRAC_BITS'($urandom_range(16'hFFFF));
        endcase
        cell_bits = cell_idx[4:0];
        return {cell_bits, f};
    endfunction

    task automatic queue_write(input int addr, input logic [VALUE_W-1:0] value,
                               input bit hold);
        t_grid_beat b;
        b           = '{default: '0};
        b.operation = OP_WRITE;
        b.addr      = addr[ADDR_W-1:0];
        b.value     = value;
        b.hold      = hold;
        pending_beats = {pending_beats, b};
        cells_loaded[addr] = 1'b1;
        beats_queued++;
    endtask

    // Loads any corner not yet written (or all of them with a fill), then queries
    task automatic queue_query(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                               input logic [POS_W-1:0] pz, input bit hold,
                               input bit use_fill, input logic [VALUE_W-1:0] fill);
        int     cx[2], cy[2], cz[2];
        longint wx[2], wy[2], wz[2];
        int     a;
        t_grid_beat b;
        resolve_axis(px, CELLS_X, cx[0], cx[1], wx[0], wx[1]);
        resolve_axis(py, CELLS_Y, cy[0], cy[1], wy[0], wy[1]);
        resolve_axis(pz, CELLS_Z, cz[0], cz[1], wz[0], wz[1]);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                for (int k = 0; k < 2; k++) begin
                    a = corner_addr(cx[i], cy[j], cz[k]);
                    if (use_fill || !cells_loaded[a])
                        queue_write(a, use_fill ? fill : pick_value(), 1'b0);
                end
        b           = '{default: '0};
        b.operation = OP_INTERP;
        b.addr      = ADDR_W'($urandom_range(STORE_DEPTH - 1));
        b.value     = $urandom();
        b.px        = px;
        b.py        = py;
        b.pz        = pz;
        b.hold      = hold;
        pending_beats = {pending_beats, b};
        beats_queued++;
    endtask

    // Grid edges, zero offsets and uniform extreme blocks
    task automatic queue_directed();
        if (centred_mode) begin
            queue_query({5'd3, 16'hC000}, {5'd4, 16'hC000}, {5'd5, 16'hC000},
                        1'b0, 1'b1, 32'h7FFF_FFFF);
            queue_query({5'd7, 16'h4000}, {5'd8, 16'h8000}, {5'd9, 16'h0000},
                        1'b0, 1'b1, 32'h8000_0000);
        end
        queue_write(0, 32'h7FFF_FFFF, 1'b0);
        queue_write(STORE_DEPTH - 1, 32'h8000_0000, 1'b0);
        queue_query('0, '0, '0, 1'b0, 1'b0, '0);
        queue_query(21'h1F_FFFF, 21'h1F_FFFF, 21'h1F_FFFF, 1'b0, 1'b0, '0);
        queue_query({5'd31, 16'h8000}, {5'd0, 16'h8000}, {5'd31, 16'h0000},
                    1'b0, 1'b0, '0);
        queue_query({5'd0, 16'h0000}, {5'd31, 16'hFFFF}, {5'd16, 16'h8000},
                    1'b0, 1'b0, '0);
    endtask

    task automatic queue_random_beat(input bit hold);
        bit near;
        if ($urandom_range(9) == 0) begin
            queue_write($urandom_range(STORE_DEPTH - 1), pick_value(), hold);
        end else begin
            near = ($urandom_range(3) != 0);
            queue_query(pick_axis(near), pick_axis(near), pick_axis(near),
                        hold || ($urandom_range(29) == 0), 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_valid || expected_interp.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic program_mode(input bit mode);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cfg_valid    <= 1'b0;
        centred_mode = mode;
    endtask

    // Input driver: retire the accepted beat into the model, then present the next
    always @(posedge i_clk) begin : beat_driver
        t_grid_beat     b;
        t_interp_expect e;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                if (op_r == OP_WRITE) begin
                    grid_model[addr_r] = value_r;
                    writes_taken++;
                end else begin
                    e.px    = px_r;
                    e.py    = py_r;
                    e.pz    = pz_r;
                    e.value = predict_interp(px_r, py_r, pz_r);
                    expected_interp = {expected_interp, e};
                    queries_taken++;
                end
            end
            if (!in_valid || !o_in_stall) begin
                if (pending_beats.size() != 0
                    && !(pending_beats[0].hold && expected_interp.size() != 0)
                    && $urandom_range(99) >= send_gap_pct) begin
                    b = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    op_r     <= b.operation;
                    addr_r   <= b.addr;
                    value_r  <= b.value;
                    px_r     <= b.px;
                    py_r     <= b.py;
                    pz_r     <= b.pz;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall
    always @(posedge i_clk) begin : result_monitor
        t_interp_expect e;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_interp.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", o_interp_value));
                end else begin
                    e = expected_interp.pop_front();
                    results_checked++;
                    if (o_interp_value !== e.value)
                        report_mismatch($sformatf("pos (%h,%h,%h): got %h want %h",
                                        e.px, e.py, e.pz, o_interp_value, e.value));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("tb_periodic_trilinear_grid_interp failed");
            $finish;
        end
    end

    // Phase sequencer: mode, idle mix, directed and random beats
    initial begin : sequencer
        bit phase_mode[PHASES];
        int phase_send[PHASES];
        int phase_recv[PHASES];
        int start;
        phase_mode = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_send = '{0, 0, 87, 0, 13, 13};
        phase_recv = '{0, 0, 0, 87, 13, 13};
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            repeat (SETTLE) @(negedge i_clk);
            program_mode(phase_mode[p]);
            @(negedge i_clk);
            send_gap_pct   = phase_send[p];
            recv_stall_pct = phase_recv[p];
            if (p < 2)
                queue_directed();
            start = beats_queued;
            while (beats_queued - start < RAND_BEATS)
                queue_random_beat(beats_queued == start);
        end
        wait_drained();
        repeat (SETTLE + 20) @(negedge i_clk);
        if (expected_interp.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_interp.size()));
        $display("Checked %0d interpolations from %0d queries and %0d grid writes,",
                 results_checked, queries_taken, writes_taken);
        $display("centered and corner offsets, wrapped edges, gaps, stalls and drain pauses.");
        if (mismatches == 0)
            $display("tb_periodic_trilinear_grid_interp passed");
        else
            $display("tb_periodic_trilinear_grid_interp failed");
        $finish;
    end

endmodule

`default_nettype wire
